@@ hw/rtl/mpm_pkg.sv @@
// ----------------------------------------------------------------------------
// mpm_pkg
// Shared types and constants for the multi-pattern matcher.
// ----------------------------------------------------------------------------
package mpm_pkg;

    typedef logic [1:0] t_op;

    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_END    = 2'd1;
    localparam t_op OP_BUILD  = 2'd2;
    localparam t_op OP_MATCH  = 2'd3;

    localparam int NODE_INDEX_W = 10;
    localparam int SYMBOL_W     = 5;
    localparam int COUNT_W      = 8;

    typedef logic [COUNT_W-1:0] t_count;

    localparam t_count COUNT_MAX = 8'hFF;

endpackage

@@ hw/rtl/mpm_ram.sv @@
// ----------------------------------------------------------------------------
// mpm_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/multi_pattern_matcher.sv @@
// ----------------------------------------------------------------------------
// multi_pattern_matcher
// Aho-Corasick engine over a-z with the trie, links, counts and BFS queue
// held in synchronous RAMs.
// ----------------------------------------------------------------------------
// Usage: drive i_operation and i_symbol and pulse start while busy is low;
// the beat is taken on that edge. busy stays high until the result has been
// shown. Each result appears for one cycle with o_valid high and carries
// o_node_index, o_pattern_count and o_status; the receiver cannot stall it.
// Steps from the start edge to the result:
//   insert, end: read the child or count table, update it, read the count
//     (an insert with a letter beyond the alphabet skips to the count read)
//   match: read the child, following failure links while it is empty (a stray
//     letter resets to the root); build: a BFS over every node's letter slots.
// busy drops in the cycle after each result; the next start is taken then.
// One item is in flight at a time; the child-table read port sets the pace.
// After reset the child table is swept to zero, one entry per cycle, over
// all NODE_COUNT*ALPHABET_SIZE entries (26624 by default), with busy high.
// ----------------------------------------------------------------------------
module multi_pattern_matcher #(
    parameter int NODE_COUNT    = 1024,
    parameter int ALPHABET_SIZE = 26,
    parameter int QUEUE_DEPTH   = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  mpm_pkg::t_op                        i_operation,
    input  logic [mpm_pkg::SYMBOL_W-1:0]        i_symbol,
    output logic                                o_valid,
    output logic [mpm_pkg::NODE_INDEX_W-1:0]    o_node_index,
    output logic [mpm_pkg::COUNT_W-1:0]         o_pattern_count,
    output logic                                o_status
);

    localparam int NW = $clog2(NODE_COUNT);
    localparam int UW = NW + 1;
    localparam int SW = $clog2(ALPHABET_SIZE);
    localparam int CD = NODE_COUNT * ALPHABET_SIZE;
    localparam int AW = $clog2(CD);
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_INS_EV = 4'd2;
    localparam logic [3:0] S_END_EV = 4'd3;
    localparam logic [3:0] S_MA_EV  = 4'd4;
    localparam logic [3:0] S_MA_FL  = 4'd5;
    localparam logic [3:0] S_RPT    = 4'd6;
    localparam logic [3:0] S_OUT    = 4'd7;
    localparam logic [3:0] S_B_INIT = 4'd8;
    localparam logic [3:0] S_B_POP  = 4'd9;
    localparam logic [3:0] S_B_U    = 4'd10;
    localparam logic [3:0] S_B_CH   = 4'd11;
    localparam logic [3:0] S_B_CHE  = 4'd12;
    localparam logic [3:0] S_B_FL   = 4'd13;
    localparam logic [3:0] S_B_N    = 4'd14;
    localparam logic [3:0] S_B_SET  = 4'd15;

    function automatic logic [AW-1:0] caddr(input logic [NW-1:0] node,
                                            input logic [SW-1:0] sym);
        return AW'(node) * AW'(ALPHABET_SIZE) + AW'(sym);
    endfunction

    logic [3:0]    r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [SW-1:0] r_sym, n_sym;
    logic [NW-1:0] r_ic, n_ic;
    logic [NW-1:0] r_mc, n_mc;
    logic [UW-1:0] r_nu, n_nu;
    logic [NW-1:0] r_node, n_node;
    logic          r_status, n_status;
    logic [NW-1:0] r_p, n_p;
    logic [UW-1:0] r_guard, n_guard;
    logic [NW-1:0] r_u, n_u;
    logic [SW-1:0] r_i, n_i;
    logic [NW-1:0] r_c, n_c;
    logic [NW-1:0] r_link, n_link;
    logic [QW-1:0] r_head, n_head;
    logic [QW-1:0] r_tail, n_tail;
    logic [FW-1:0] r_fill, n_fill;

    logic          c_we, c_re;
    logic [AW-1:0] c_waddr, c_raddr;
    logic [NW-1:0] c_wdata, c_rdata;
    logic          f_we, f_re;
    logic [NW-1:0] f_waddr, f_raddr, f_wdata, f_rdata;
    logic          k_we, k_re;
    logic [NW-1:0] k_waddr, k_raddr;
    mpm_pkg::t_count k_wdata, k_rdata;
    logic          q_we, q_re;
    logic [QW-1:0] q_waddr, q_raddr;
    logic [NW-1:0] q_wdata, q_rdata;

    logic          sym_ok;
    logic [SW-1:0] in_sym;
    logic [NW-1:0] new_node;

    assign sym_ok   = 32'(i_symbol) < ALPHABET_SIZE;
    assign in_sym   = SW'(i_symbol);
    assign new_node = NW'(r_nu);

    mpm_ram #(.WIDTH(NW), .DEPTH(CD)) u_child (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(c_wdata),
        .i_re(c_re), .i_raddr(c_raddr), .o_rdata(c_rdata)
    );

    mpm_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_fail (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_re(f_re), .i_raddr(f_raddr), .o_rdata(f_rdata)
    );

    mpm_ram #(.WIDTH(mpm_pkg::COUNT_W), .DEPTH(NODE_COUNT)) u_count (
        .i_clk(i_clk), .i_we(k_we), .i_waddr(k_waddr), .i_wdata(k_wdata),
        .i_re(k_re), .i_raddr(k_raddr), .o_rdata(k_rdata)
    );

    mpm_ram #(.WIDTH(NW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_re(q_re), .i_raddr(q_raddr), .o_rdata(q_rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_sym    = r_sym;
        n_ic     = r_ic;
        n_mc     = r_mc;
        n_nu     = r_nu;
        n_node   = r_node;
        n_status = r_status;
        n_p      = r_p;
        n_guard  = r_guard;
        n_u      = r_u;
        n_i      = r_i;
        n_c      = r_c;
        n_link   = r_link;
        n_head   = r_head;
        n_tail   = r_tail;
        n_fill   = r_fill;
        c_we = 1'b0; c_waddr = '0; c_wdata = '0; c_re = 1'b0; c_raddr = '0;
        f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_re = 1'b0; f_raddr = '0;
        k_we = 1'b0; k_waddr = '0; k_wdata = '0; k_re = 1'b0; k_raddr = '0;
        q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_re = 1'b0; q_raddr = '0;

        case (r_state)
            S_CLEAR: begin
                c_we    = 1'b1;
                c_waddr = r_clr;
                if (r_clr == '0) begin
                    k_we = 1'b1;
                end
                if (r_clr == AW'(CD - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_sym    = in_sym;
                    n_status = 1'b0;
                    case (i_operation)
                        mpm_pkg::OP_INSERT: begin
                            if (sym_ok) begin
                                c_re    = 1'b1;
                                c_raddr = caddr(r_ic, in_sym);
                                n_state = S_INS_EV;
                            end else begin
                                n_node  = r_ic;
                                n_state = S_RPT;
                            end
                        end
                        mpm_pkg::OP_END: begin
                            k_re    = 1'b1;
                            k_raddr = r_ic;
                            n_node  = r_ic;
                            n_ic    = '0;
                            n_state = S_END_EV;
                        end
                        mpm_pkg::OP_BUILD: begin
                            n_state = S_B_INIT;
                        end
                        default: begin
                            if (sym_ok) begin
                                c_re    = 1'b1;
                                c_raddr = caddr(r_mc, in_sym);
                                n_p     = r_mc;
                                n_guard = '0;
                                n_state = S_MA_EV;
                            end else begin
                                n_mc    = '0;
                                n_node  = '0;
                                n_state = S_RPT;
                            end
                        end
                    endcase
                end
            end
            S_INS_EV: begin
                n_state = S_RPT;
                if (c_rdata != '0) begin
                    n_ic   = c_rdata;
                    n_node = c_rdata;
                end else if (r_nu >= UW'(NODE_COUNT)) begin
                    n_status = 1'b1;
                    n_node   = r_ic;
                end else begin
                    c_we    = 1'b1;
                    c_waddr = caddr(r_ic, r_sym);
                    c_wdata = new_node;
                    f_we    = 1'b1;
                    f_waddr = new_node;
                    k_we    = 1'b1;
                    k_waddr = new_node;
                    n_nu    = r_nu + 1'b1;
                    n_ic    = new_node;
                    n_node  = new_node;
                end
            end
            S_END_EV: begin
                k_we    = 1'b1;
                k_waddr = r_node;
                k_wdata = (k_rdata != mpm_pkg::COUNT_MAX) ? k_rdata + 1'b1 : k_rdata;
                n_state = S_RPT;
            end
            S_MA_EV: begin
                if (c_rdata == '0 && r_p != '0 && r_guard < r_nu) begin
                    f_re    = 1'b1;
                    f_raddr = r_p;
                    n_state = S_MA_FL;
                end else begin
                    n_mc    = c_rdata;
                    n_node  = c_rdata;
                    n_state = S_RPT;
                end
            end
            S_MA_FL: begin
                n_p     = f_rdata;
                n_guard = r_guard + 1'b1;
                c_re    = 1'b1;
                c_raddr = caddr(f_rdata, r_sym);
                n_state = S_MA_EV;
            end
            S_RPT: begin
                k_re    = 1'b1;
                k_raddr = r_node;
                n_state = S_OUT;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            S_B_INIT: begin
                f_we    = 1'b1;
                q_we    = 1'b1;
                n_head  = '0;
                n_tail  = QW'(1);
                n_fill  = FW'(1);
                n_state = S_B_POP;
            end
            S_B_POP: begin
                if (r_fill == '0) begin
                    n_node  = '0;
                    n_state = S_RPT;
                end else begin
                    q_re    = 1'b1;
                    q_raddr = r_head;
                    n_head  = (r_head == QW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    n_fill  = r_fill - 1'b1;
                    n_state = S_B_U;
                end
            end
            S_B_U: begin
                n_u     = q_rdata;
                n_i     = '0;
                n_state = S_B_CH;
            end
            S_B_CH: begin
                c_re    = 1'b1;
                c_raddr = caddr(r_u, r_i);
                n_state = S_B_CHE;
            end
            S_B_CHE: begin
                n_c = c_rdata;
                if (c_rdata == '0) begin
                    if (r_i == SW'(ALPHABET_SIZE - 1)) begin
                        n_state = S_B_POP;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_B_CH;
                    end
                end else if (r_u == '0) begin
                    n_link  = '0;
                    n_state = S_B_SET;
                end else begin
                    f_re    = 1'b1;
                    f_raddr = r_u;
                    n_guard = '0;
                    n_state = S_B_FL;
                end
            end
            S_B_FL: begin
                n_p     = f_rdata;
                c_re    = 1'b1;
                c_raddr = caddr(f_rdata, r_i);
                n_state = S_B_N;
            end
            S_B_N: begin
                if (c_rdata != '0) begin
                    n_link  = c_rdata;
                    n_state = S_B_SET;
                end else if (r_p == '0 || r_guard >= r_nu) begin
                    n_link  = '0;
                    n_state = S_B_SET;
                end else begin
                    f_re    = 1'b1;
                    f_raddr = r_p;
                    n_guard = r_guard + 1'b1;
                    n_state = S_B_FL;
                end
            end
            S_B_SET: begin
                f_we    = 1'b1;
                f_waddr = r_c;
                f_wdata = r_link;
                if (r_fill < FW'(QUEUE_DEPTH)) begin
                    q_we    = 1'b1;
                    q_waddr = r_tail;
                    q_wdata = r_c;
                    n_tail  = (r_tail == QW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
                    n_fill  = r_fill + 1'b1;
                end
                if (r_i == SW'(ALPHABET_SIZE - 1)) begin
                    n_state = S_B_POP;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_B_CH;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_ic    <= '0;
            r_mc    <= '0;
            r_nu    <= UW'(1);
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_ic    <= n_ic;
            r_mc    <= n_mc;
            r_nu    <= n_nu;
        end
        r_sym    <= n_sym;
        r_node   <= n_node;
        r_status <= n_status;
        r_p      <= n_p;
        r_guard  <= n_guard;
        r_u      <= n_u;
        r_i      <= n_i;
        r_c      <= n_c;
        r_link   <= n_link;
        r_head   <= n_head;
        r_tail   <= n_tail;
        r_fill   <= n_fill;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = (r_state == S_OUT);
    assign o_node_index    = mpm_pkg::NODE_INDEX_W'(r_node);
    assign o_pattern_count = k_rdata;
    assign o_status        = r_status;

endmodule
